// ----- hw/rtl/sdinit_pkg.sv -----
// types, codes and frame builder shared by the sd card init sequencer
`default_nettype none

package sdinit_pkg;

    // input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RESP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_APP_CMD   = 3'd1;
    localparam logic [2:0] ERR_OP_COND   = 3'd2;
    localparam logic [2:0] ERR_NOT_READY = 3'd3;
    localparam logic [2:0] ERR_CID       = 3'd4;
    localparam logic [2:0] ERR_RCA       = 3'd5;
    localparam logic [2:0] ERR_SELECT    = 3'd6;
    localparam logic [2:0] ERR_BLOCKLEN  = 3'd7;

    // command indexes
    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_ALL_CID    = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
    localparam logic [5:0] CMD_SELECT     = 6'd7;
    localparam logic [5:0] CMD_IF_COND    = 6'd8;
    localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
    localparam logic [5:0] CMD_OP_COND    = 6'd41;
    localparam logic [5:0] CMD_APP_PREFIX = 6'd55;

    localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;

    // configuration register indexes
    localparam logic [1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_RETRY    = 2'd1;
    localparam logic [1:0] REG_BLOCKLEN = 2'd2;
    localparam logic [1:0] REG_OP_ARG   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] frame;
        logic        expects;
        logic [15:0] card_address;
        logic [2:0]  err;
        logic        last;
    } t_result;

    // 48-bit frame: start/transmit bits, index, argument, crc7 (x^7+x^3+1), end bit
    function automatic logic [47:0] make_frame(logic [5:0] idx, logic [31:0] arg);
        logic [39:0] head;
        logic [6:0]  crc;
        logic        fb;
        head = {2'b01, idx, arg};
        crc  = 7'd0;
        for (int i = 39; i >= 0; i--) begin
            fb  = crc[6] ^ head[i];
            crc = {crc[5:0], 1'b0};
            if (fb) begin
                crc = crc ^ 7'h09;
            end
        end
        return {head, crc, 1'b1};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sd_card_init_sequencer.sv -----
// sd card initialization sequencer: command frames from start, response and tick transactions
`default_nettype none
// Usage
//   input channel (i_in_valid / o_in_stall) carries one transaction per item:
//   start, response arrived (with the 32-bit response word) or one timer tick.
//   output channel (o_out_valid / i_out_stall) carries the results: a 48-bit
//   command frame, init done or init failed; o_last_of_run marks the final
//   result of one input transaction. a start gives two results (CMD0 then
//   CMD8); responses and ticks give one or none.
// Pipeline and throughput
//   an accepted transaction waits in the input register while it is decoded;
//   its results load into a two-entry result buffer when decode fires.
//   one input transaction per cycle for items with at most one result, while
//   the receiver does not stall; a start holds the result buffer for two
//   output transactions.
// Stall
//   decode fires only once the result buffer will be empty; a result stuck
//   behind a stalled receiver leaves the input register full and raises o_in_stall
// Reset
//   synchronous, active low: phase idle, counters, card address cleared, buffers empty,
//   configuration at defaults, written by the user only while idle (not enforced)

module sd_card_init_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [31:0] i_response_word,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [47:0]      o_command_frame,
    output logic             o_expects_response,
    output logic [15:0]      o_card_address,
    output logic [2:0]       o_error_code,
    output logic             o_last_of_run
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_CMD8,
        PH_CMD55,
        PH_ACMD41,
        PH_CMD2,
        PH_CMD3,
        PH_CMD7,
        PH_CMD16,
        PH_DONE,
        PH_FAILED
    } t_phase;

    // configuration registers
    logic [15:0] r_timeout;
    logic [15:0] r_retry_limit;
    logic [12:0] r_block_len;
    logic [31:0] r_op_arg;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_opcode;
    logic [31:0] r_resp;

    // sequencer state
    t_phase      r_phase, n_phase;
    logic [15:0] r_wait, n_wait;
    logic [15:0] r_retry, n_retry;
    logic [15:0] r_rca, n_rca;

    // result buffer, entry 0 is the head
    sdinit_pkg::t_result r_pend0, r_pend1;
    logic [1:0]          r_cnt;

    // decode outputs
    sdinit_pkg::t_result res0, res1;
    logic [1:0]          res_cnt;
    logic                fire, pop;

    logic [1:0]  one_kind;
    logic [5:0]  one_idx;
    logic [31:0] one_arg;
    logic        one_exp;
    logic [2:0]  one_err;
    logic        app, do_fail, waiting;
    logic [2:0]  fail_err;
    logic [15:0] wait_inc;

    assign pop         = o_out_valid && !i_out_stall;
    assign fire        = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop));
    assign o_in_stall  = r_in_valid && !fire;
    assign o_out_valid = (r_cnt != 2'd0);

    assign o_result_kind      = r_pend0.kind;
    assign o_command_frame    = r_pend0.frame;
    assign o_expects_response = r_pend0.expects;
    assign o_card_address     = r_pend0.card_address;
    assign o_error_code       = r_pend0.err;
    assign o_last_of_run      = r_pend0.last;

    assign waiting  = (r_phase != PH_IDLE) && (r_phase != PH_DONE) && (r_phase != PH_FAILED);
    assign wait_inc = (r_wait == 16'hFFFF) ? r_wait : r_wait + 16'd1;

    // sequencer decode for the item in the input register
    always_comb begin
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_retry  = r_retry;
        n_rca    = r_rca;
        res_cnt  = 2'd0;
        one_kind = sdinit_pkg::KIND_CMD;
        one_idx  = sdinit_pkg::CMD_GO_IDLE;
        one_arg  = 32'd0;
        one_exp  = 1'b1;
        one_err  = sdinit_pkg::ERR_NONE;
        app      = 1'b0;
        do_fail  = 1'b0;
        fail_err = sdinit_pkg::ERR_NONE;

        case (r_opcode)
            sdinit_pkg::OP_START: begin
                n_wait  = 16'd0;
                n_retry = 16'd0;
                n_rca   = 16'd0;
                n_phase = PH_CMD8;
                res_cnt = 2'd2;
            end
            sdinit_pkg::OP_RESP: begin
                case (r_phase)
                    PH_CMD8: begin
                        app = 1'b1;
                    end
                    PH_CMD55: begin
                        one_idx = sdinit_pkg::CMD_OP_COND;
                        one_arg = r_op_arg;
                        n_phase = PH_ACMD41;
                        n_wait  = 16'd0;
                        res_cnt = 2'd1;
                    end
                    PH_ACMD41: begin
                        if (r_resp[31]) begin
                            one_idx = sdinit_pkg::CMD_ALL_CID;
                            n_phase = PH_CMD2;
                            n_wait  = 16'd0;
                            res_cnt = 2'd1;
                        end else if (r_retry >= r_retry_limit) begin
                            do_fail  = 1'b1;
                            fail_err = sdinit_pkg::ERR_NOT_READY;
                        end else begin
                            app = 1'b1;
                        end
                    end
                    PH_CMD2: begin
                        one_idx = sdinit_pkg::CMD_SEND_RCA;
                        n_phase = PH_CMD3;
                        n_wait  = 16'd0;
                        res_cnt = 2'd1;
                    end
                    PH_CMD3: begin
                        n_rca   = r_resp[31:16];
                        one_idx = sdinit_pkg::CMD_SELECT;
                        one_arg = {r_resp[31:16], 16'h0000};
                        n_phase = PH_CMD7;
                        n_wait  = 16'd0;
                        res_cnt = 2'd1;
                    end
                    PH_CMD7: begin
                        one_idx = sdinit_pkg::CMD_BLOCKLEN;
                        one_arg = {19'd0, r_block_len};
                        n_phase = PH_CMD16;
                        n_wait  = 16'd0;
                        res_cnt = 2'd1;
                    end
                    PH_CMD16: begin
                        one_kind = sdinit_pkg::KIND_DONE;
                        one_exp  = 1'b0;
                        n_phase  = PH_DONE;
                        n_wait   = 16'd0;
                        res_cnt  = 2'd1;
                    end
                    default: begin
                    end
                endcase
            end
            sdinit_pkg::OP_TICK: begin
                if (waiting) begin
                    n_wait = wait_inc;
                    if (wait_inc >= r_timeout) begin
                        do_fail = 1'b1;
                        case (r_phase)
                            PH_CMD8: begin
                                // missing interface condition reply is tolerated
                                do_fail = 1'b0;
                                app     = 1'b1;
                            end
                            PH_CMD55:  fail_err = sdinit_pkg::ERR_APP_CMD;
                            PH_ACMD41: fail_err = sdinit_pkg::ERR_OP_COND;
                            PH_CMD2:   fail_err = sdinit_pkg::ERR_CID;
                            PH_CMD3:   fail_err = sdinit_pkg::ERR_RCA;
                            PH_CMD7:   fail_err = sdinit_pkg::ERR_SELECT;
                            default:   fail_err = sdinit_pkg::ERR_BLOCKLEN;
                        endcase
                    end
                end
            end
            default: begin
            end
        endcase

        // app command prefix, counts one operating condition attempt
        if (app) begin
            n_retry = (r_retry == 16'hFFFF) ? r_retry : r_retry + 16'd1;
            one_idx = sdinit_pkg::CMD_APP_PREFIX;
            one_arg = {r_rca, 16'h0000};
            n_phase = PH_CMD55;
            n_wait  = 16'd0;
            res_cnt = 2'd1;
        end

        if (do_fail) begin
            one_kind = sdinit_pkg::KIND_FAIL;
            one_exp  = 1'b0;
            one_err  = fail_err;
            n_phase  = PH_FAILED;
            n_wait   = 16'd0;
            res_cnt  = 2'd1;
        end

        if (r_opcode == sdinit_pkg::OP_START) begin
            res0.kind         = sdinit_pkg::KIND_CMD;
            res0.frame        = sdinit_pkg::make_frame(sdinit_pkg::CMD_GO_IDLE, 32'd0);
            res0.expects      = 1'b0;
            res0.card_address = 16'd0;
            res0.err          = sdinit_pkg::ERR_NONE;
            res0.last         = 1'b0;
            res1.kind         = sdinit_pkg::KIND_CMD;
            res1.frame        = sdinit_pkg::make_frame(sdinit_pkg::CMD_IF_COND,
                                                       sdinit_pkg::IF_COND_ARG);
            res1.expects      = 1'b1;
            res1.card_address = 16'd0;
            res1.err          = sdinit_pkg::ERR_NONE;
            res1.last         = 1'b1;
        end else begin
            res0.kind         = one_kind;
            res0.frame        = (one_kind == sdinit_pkg::KIND_CMD) ?
                                sdinit_pkg::make_frame(one_idx, one_arg) : 48'd0;
            res0.expects      = one_exp;
            res0.card_address = n_rca;
            res0.err          = one_err;
            res0.last         = 1'b1;
            res1              = res0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= 16'd1000;
            r_retry_limit <= 16'd1000;
            r_block_len   <= 13'd512;
            r_op_arg      <= 32'h4030_0000;
            r_in_valid    <= 1'b0;
            r_phase       <= PH_IDLE;
            r_wait        <= 16'd0;
            r_retry       <= 16'd0;
            r_rca         <= 16'd0;
            r_cnt         <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdinit_pkg::REG_TIMEOUT:  r_timeout     <= i_cfg_data[15:0];
                    sdinit_pkg::REG_RETRY:    r_retry_limit <= i_cfg_data[15:0];
                    sdinit_pkg::REG_BLOCKLEN: r_block_len   <= i_cfg_data[12:0];
                    sdinit_pkg::REG_OP_ARG:   r_op_arg      <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // input register
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end

            // decode stage and result buffer
            if (fire) begin
                r_phase <= n_phase;
                r_wait  <= n_wait;
                r_retry <= n_retry;
                r_rca   <= n_rca;
                r_cnt   <= res_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_opcode <= i_opcode;
            r_resp   <= i_response_word;
        end
        if (fire) begin
            r_pend0 <= res0;
            r_pend1 <= res1;
        end else if (pop) begin
            r_pend0 <= r_pend1;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sd_card_init_sequencer_test.sv -----
// self-checking testbench for the sd card init sequencer: predictor, scoreboard and stimulus
module sd_card_init_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    // sequencer position as tracked by the predictor
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IF_COND,
        ST_APP_CMD,
        ST_OP_COND,
        ST_CID,
        ST_RCA,
        ST_SELECT,
        ST_BLOCKLEN,
        ST_DONE,
        ST_FAILED
    } t_seq_state;

    class t_init_scoreboard;
        // configuration copy
        logic [15:0] timeout_ticks;
        logic [15:0] retry_limit;
        logic [12:0] block_len;
        logic [31:0] op_arg;
        // sequencer state copy
        t_seq_state  state;
        logic [15:0] ticks_waited;
        logic [15:0] attempts;
        logic [15:0] rca;
        // results owed by the block, oldest first
        sdinit_pkg::t_result expected_results[$];
        sdinit_pkg::t_result item_results[$];
        int          errors;

        function new();
            timeout_ticks = 16'd1000;
            retry_limit   = 16'd1000;
            block_len     = 13'd512;
            op_arg        = 32'h4030_0000;
            state         = ST_IDLE;
            ticks_waited  = '0;
            attempts      = '0;
            rca           = '0;
            errors        = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                sdinit_pkg::REG_TIMEOUT:  timeout_ticks = data[15:0];
                sdinit_pkg::REG_RETRY:    retry_limit   = data[15:0];
                sdinit_pkg::REG_BLOCKLEN: block_len     = data[12:0];
                sdinit_pkg::REG_OP_ARG:   op_arg        = data;
                default: ;
            endcase
        endfunction

        // crc7 with taps x^3 and x^0, fed msb first over the 40 header bits
        function logic [47:0] frame_for(logic [5:0] idx, logic [31:0] arg);
            logic [39:0] hdr;
            logic [6:0]  rem;
            logic        top;
            hdr = {2'b01, idx, arg};
            rem = '0;
            for (int n = 0; n < 40; n++) begin
                top = rem[6] ^ hdr[39 - n];
                rem = rem << 1;
                if (top) begin
                    rem = rem ^ 7'b000_1001;
                end
            end
            return {hdr, rem, 1'b1};
        endfunction

        function void emit(logic [1:0] kind, logic [47:0] frame, logic expects,
                           logic [2:0] err);
            sdinit_pkg::t_result r;
            r.kind         = kind;
            r.frame        = frame;
            r.expects      = expects;
            r.card_address = rca;
            r.err          = err;
            r.last         = 1'b0;
            item_results.push_back(r);
        endfunction

        function void issue(logic [5:0] idx, logic [31:0] arg, logic expects,
                            t_seq_state nxt);
            emit(sdinit_pkg::KIND_CMD, frame_for(idx, arg), expects, sdinit_pkg::ERR_NONE);
            state        = nxt;
            ticks_waited = '0;
        endfunction

        function void abort(logic [2:0] err);
            emit(sdinit_pkg::KIND_FAIL, 48'd0, 1'b0, err);
            state        = ST_FAILED;
            ticks_waited = '0;
        endfunction

        function void issue_app_prefix();
            if (attempts != 16'hFFFF) begin
                attempts++;
            end
            issue(sdinit_pkg::CMD_APP_PREFIX, {rca, 16'h0000}, 1'b1, ST_APP_CMD);
        endfunction

        // notes an accepted input and queues the results it causes
        function void note_transaction(logic [1:0] op, logic [31:0] resp);
            item_results.delete();
            case (op)
                sdinit_pkg::OP_START: begin
                    ticks_waited = '0;
                    attempts     = '0;
                    rca          = '0;
                    issue(sdinit_pkg::CMD_GO_IDLE, 32'd0, 1'b0, ST_IDLE);
                    issue(sdinit_pkg::CMD_IF_COND, sdinit_pkg::IF_COND_ARG, 1'b1, ST_IF_COND);
                end
                sdinit_pkg::OP_RESP: begin
                    case (state)
                        ST_IF_COND: issue_app_prefix();
                        ST_APP_CMD: issue(sdinit_pkg::CMD_OP_COND, op_arg, 1'b1, ST_OP_COND);
                        ST_OP_COND: begin
                            if (resp[31]) begin
                                issue(sdinit_pkg::CMD_ALL_CID, 32'd0, 1'b1, ST_CID);
                            end else if (attempts >= retry_limit) begin
                                abort(sdinit_pkg::ERR_NOT_READY);
                            end else begin
                                issue_app_prefix();
                            end
                        end
                        ST_CID: issue(sdinit_pkg::CMD_SEND_RCA, 32'd0, 1'b1, ST_RCA);
                        ST_RCA: begin
                            rca = resp[31:16];
                            issue(sdinit_pkg::CMD_SELECT, {resp[31:16], 16'h0000}, 1'b1,
                                  ST_SELECT);
                        end
                        ST_SELECT: issue(sdinit_pkg::CMD_BLOCKLEN, {19'd0, block_len}, 1'b1,
                                         ST_BLOCKLEN);
                        ST_BLOCKLEN: begin
                            emit(sdinit_pkg::KIND_DONE, 48'd0, 1'b0, sdinit_pkg::ERR_NONE);
                            state        = ST_DONE;
                            ticks_waited = '0;
                        end
                        default: ;
                    endcase
                end
                sdinit_pkg::OP_TICK: begin
                    if ((state >= ST_IF_COND) && (state <= ST_BLOCKLEN)) begin
                        if (ticks_waited != 16'hFFFF) begin
                            ticks_waited++;
                        end
                        if (ticks_waited >= timeout_ticks) begin
                            case (state)
                                ST_IF_COND: issue_app_prefix();
                                ST_APP_CMD: abort(sdinit_pkg::ERR_APP_CMD);
                                ST_OP_COND: abort(sdinit_pkg::ERR_OP_COND);
                                ST_CID:     abort(sdinit_pkg::ERR_CID);
                                ST_RCA:     abort(sdinit_pkg::ERR_RCA);
                                ST_SELECT:  abort(sdinit_pkg::ERR_SELECT);
                                default:    abort(sdinit_pkg::ERR_BLOCKLEN);
                            endcase
                        end
                    end
                end
                default: ;
            endcase
            if (item_results.size() > 0) begin
                item_results[item_results.size() - 1].last = 1'b1;
            end
            foreach (item_results[i]) begin
                expected_results.push_back(item_results[i]);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(sdinit_pkg::t_result got);
            sdinit_pkg::t_result want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual kind %0d frame %0h",
                         $time, got.kind, got.frame);
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", 64'(want.kind), 64'(got.kind));
            compare_field("command_frame", 64'(want.frame), 64'(got.frame));
            compare_field("expects_response", 64'(want.expects), 64'(got.expects));
            compare_field("card_address", 64'(want.card_address), 64'(got.card_address));
            compare_field("error_code", 64'(want.err), 64'(got.err));
            compare_field("last_of_run", 64'(want.last), 64'(got.last));
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void report_leftover();
            foreach (expected_results[i]) begin
                errors++;
                $display("%0t: missing result, expected kind %0d frame %0h, actual none",
                         $time, expected_results[i].kind, expected_results[i].frame);
            end
        endfunction
    endclass

    // opcode outside the defined set, must be dropped by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // roughly this many input transactions in total
    localparam int ITEM_TARGET = 1450;
    // quiet cycles after the last result, covers decode of result-less ticks
    localparam int SETTLE_CYCLES = 6;
    // bound on the final wait for outstanding results
    localparam int DRAIN_LIMIT = 5000;
    // watchdog, well above the slowest legal run
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_index     = '0;
    logic [31:0] i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_opcode        = '0;
    logic [31:0] i_response_word = '0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [1:0]  o_result_kind;
    logic [47:0] o_command_frame;
    logic        o_expects_response;
    logic [15:0] o_card_address;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;

    t_init_scoreboard sb = new();

    // idle bounds per side, zero gives back-to-back traffic
    int in_gap_max    = 4;
    int out_gap_max   = 4;
    // one-shot long stall request for the receiver
    int out_hold      = 0;
    int sent_items    = 0;
    int cycle_count   = 0;

    sd_card_init_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_opcode           (i_opcode),
        .i_response_word    (i_response_word),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_result_kind      (o_result_kind),
        .o_command_frame    (o_command_frame),
        .o_expects_response (o_expects_response),
        .o_card_address     (o_card_address),
        .o_error_code       (o_error_code),
        .o_last_of_run      (o_last_of_run)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // output monitor: a transaction completes on valid with stall low
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_result_kind, o_command_frame, o_expects_response,
                             o_card_address, o_error_code, o_last_of_run});
        end
    end

    // receiver: random stall before each result, plus the long hold-off on request
    initial begin : receiver
        int pause;
        forever begin
            pause    = out_hold + $urandom_range(0, out_gap_max);
            out_hold = 0;
            if (pause > 0) begin
                i_out_stall <= 1'b1;
                repeat (pause) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && i_rst_n));
            @(negedge i_clk);
        end
    end

    // offer one transaction and hold it until taken; called at a falling edge.
    // valid stays high when the next transaction follows with no gap
    task automatic push_item(input logic [1:0] op, input logic [31:0] word);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_response_word <= word;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_transaction(op, word);
        sent_items++;
        @(negedge i_clk);
    endtask

    // sender pause: nothing offered until every owed result has come back
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // one init attempt: start, then mostly responses with random words
    // (acmd41 ready bit and rca random), some tick bursts and some noise
    task automatic random_run();
        int steps;
        int pick;
        push_item(sdinit_pkg::OP_START, $urandom);
        steps = $urandom_range(4, 16);
        repeat (steps) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                push_item(sdinit_pkg::OP_RESP, $urandom);
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) push_item(sdinit_pkg::OP_TICK, $urandom);
            end else if (pick < 96) begin
                push_item(OP_UNUSED, $urandom);
            end else begin
                push_item(sdinit_pkg::OP_START, $urandom);
            end
        end
    endtask

    initial begin : stimulus
        int session;
        int drain_cycles;
        logic [15:0] tmo;
        logic [15:0] lim;
        logic [12:0] blen;
        logic [31:0] arg;

        session      = 0;
        drain_cycles = 0;

        // hold synchronous reset, then release it
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset configuration
        // nothing pending: tick, response and unknown opcode are dropped
        push_item(sdinit_pkg::OP_TICK, 32'hFFFF_FFFF);
        push_item(sdinit_pkg::OP_RESP, 32'hFFFF_FFFF);
        push_item(OP_UNUSED, 32'h0000_0000);
        // full sequence with one not-ready answer and an all-ones address
        push_item(sdinit_pkg::OP_START, 32'h0000_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h0000_01AA);
        push_item(sdinit_pkg::OP_RESP, 32'h0000_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h7FFF_FFFF);
        push_item(sdinit_pkg::OP_RESP, 32'h0000_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h8000_0000);
        push_item(sdinit_pkg::OP_RESP, $urandom);
        push_item(sdinit_pkg::OP_RESP, 32'hFFFF_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h0000_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h0000_0000);
        // finished: further traffic is dropped
        push_item(sdinit_pkg::OP_RESP, 32'h8000_0000);
        push_item(sdinit_pkg::OP_TICK, 32'h0000_0000);
        wait_quiet();

        // shortest timeout and single op-cond attempt
        cfg_write(sdinit_pkg::REG_TIMEOUT, 32'd1);
        cfg_write(sdinit_pkg::REG_RETRY, 32'd1);
        cfg_write(sdinit_pkg::REG_BLOCKLEN, 32'd4096);
        cfg_write(sdinit_pkg::REG_OP_ARG, 32'hFFFF_FFFF);
        // if-cond timeout is tolerated, app prefix timeout fails
        push_item(sdinit_pkg::OP_START, 32'h0000_0000);
        push_item(sdinit_pkg::OP_TICK, 32'h0000_0000);
        push_item(sdinit_pkg::OP_TICK, 32'h0000_0000);
        // card never ready within the limit
        push_item(sdinit_pkg::OP_START, 32'h0000_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h0000_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h0000_0000);
        push_item(sdinit_pkg::OP_RESP, 32'h7FFF_FFFF);
        // restart while a command is outstanding
        push_item(sdinit_pkg::OP_START, 32'h0000_0000);
        push_item(sdinit_pkg::OP_START, 32'hFFFF_FFFF);

        // random sessions, each with its own configuration
        while (sent_items < ITEM_TARGET) begin
            wait_quiet();
            case (session)
                0: begin
                    tmo  = 16'hFFFF;
                    lim  = 16'hFFFF;
                    blen = 13'd4096;
                    arg  = 32'h0000_0000;
                end
                1: begin
                    tmo  = 16'd1;
                    lim  = 16'd1;
                    blen = 13'd1;
                    arg  = 32'hFFFF_FFFF;
                end
                default: begin
                    tmo  = ($urandom_range(0, 3) == 0) ? 16'd1000 : 16'($urandom_range(1, 5));
                    lim  = ($urandom_range(0, 3) == 0) ? 16'd1000 : 16'($urandom_range(1, 4));
                    blen = 13'($urandom_range(1, 4096));
                    arg  = $urandom;
                end
            endcase
            cfg_write(sdinit_pkg::REG_TIMEOUT, {16'd0, tmo});
            cfg_write(sdinit_pkg::REG_RETRY, {16'd0, lim});
            cfg_write(sdinit_pkg::REG_BLOCKLEN, {19'd0, blen});
            cfg_write(sdinit_pkg::REG_OP_ARG, arg);

            // every fifth session runs with no idling on either side
            in_gap_max  = (session % 5 == 3) ? 0 : 4;
            out_gap_max = (session % 5 == 3) ? 0 : 4;
            // back-pressure: receiver stalls long while the sender streams
            if (session == 2 || session == 9) begin
                out_hold   = 80;
                in_gap_max = 0;
            end
            repeat ($urandom_range(3, 8)) random_run();
            session++;
        end

        // end of stimulus: wait for owed results, then a short quiet period
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        sb.report_leftover();
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
